@@ rtl/core/rspd_pkg.sv @@
// Shared types, byte codes and result codes for the serial-protocol packet deframer.
// No dependencies; imported by the deframer and its port checker.
package rspd_pkg;

    // Largest payload the design keeps per packet, whatever max_payload says.
    localparam int unsigned MaxPayload = 4096;

    localparam int unsigned CountWidth = 13;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_INTR   = 8'h03;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_INTR    = 2'd2;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_NOT_HEX  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [1:0] REPLY_NONE  = 2'd0;
    localparam logic [1:0] REPLY_PLUS  = 2'd1;
    localparam logic [1:0] REPLY_MINUS = 2'd2;
    localparam logic [1:0] REPLY_E00   = 2'd3;

    localparam logic [0:0] REG_ACK_OFF     = 1'b0;
    localparam logic [0:0] REG_MAX_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            data;
        logic [1:0]            status;
        logic [CountWidth-1:0] length;
        logic [1:0]            reply;
    } result_t;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit_decode(input logic [7:0] c);
        logic [4:0] nib;
        nib = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            nib = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            nib = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            nib = {1'b1, 4'(c - 8'h37)};
        end
        return nib;
    endfunction

endpackage

@@ rtl/core/rsp_packet_deframer.sv @@
// A payload, end or interrupt word reaches m_ from the result register, via the skid
// register if that is stalled. Throughput: one byte per cycle, except while the skid
// register is occupied, the only time s_ready drops; frame state updates in the cycle of
// acceptance, and the one-entry skid register lets input continue while a result waits.
// Reset (aresetn low, synchronous): idle phase, empty result path, ack_off 0, max_payload 4096.
// Top level of the packet deframer; depends on rspd_pkg.
module rsp_packet_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Received byte stream.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    // Results.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [7:0]                    m_data,
    output logic [1:0]                    m_status,
    output logic [rspd_pkg::CountWidth-1:0] m_length,
    output logic [1:0]                    m_reply,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rspd_pkg::*;

    // The four phases of a frame: hunting for the start byte, payload, and the
    // two checksum digits.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_CK_HI,
        PH_CK_LO
    } phase_t;

    localparam logic [CountWidth-1:0] CapLimit = CountWidth'(MaxPayload);

    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] kept_count_reg, kept_count_next;
    logic [7:0]            running_sum_reg, running_sum_next;
    logic                  overflowed_reg, overflowed_next;
    logic [7:0]            high_digit_reg, high_digit_next;

    logic                  ack_off_reg;
    logic [CountWidth-1:0] max_payload_reg;

    // Result register and the skid entry behind it.
    logic                  out_valid_reg;
    result_t               out_word_reg;
    logic                  skid_valid_reg;
    result_t               skid_word_reg;

    logic                  accept;
    logic                  emit;
    result_t               word;
    logic [CountWidth-1:0] capacity;
    logic [4:0]            nib_hi;
    logic [4:0]            nib_lo;
    logic                  cfg_write;

    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign s_ready   = !skid_valid_reg;

    // A capacity of zero behaves as one; anything above the design limit is clipped.
    always_comb begin
        if (max_payload_reg == '0) begin
            capacity = CountWidth'(1);
        end else if (max_payload_reg > CapLimit) begin
            capacity = CapLimit;
        end else begin
            capacity = max_payload_reg;
        end
    end

    assign nib_hi = hex_digit_decode(high_digit_reg);
    assign nib_lo = hex_digit_decode(s_rx_byte);

    // Frame decoding for the byte on the input. State moves only when the byte is taken.
    always_comb begin
        phase_next       = phase_reg;
        kept_count_next  = kept_count_reg;
        running_sum_next = running_sum_reg;
        overflowed_next  = overflowed_reg;
        high_digit_next  = high_digit_reg;
        emit             = 1'b0;
        word             = '0;

        if (s_rx_byte == CHAR_INTR) begin
            // The interrupt byte aborts whatever frame is in progress.
            phase_next = PH_IDLE;
            emit       = 1'b1;
            word.kind  = KIND_INTR;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (s_rx_byte == CHAR_DOLLAR) begin
                        phase_next       = PH_DATA;
                        kept_count_next  = '0;
                        running_sum_next = '0;
                        overflowed_next  = 1'b0;
                    end
                end
                PH_DATA: begin
                    if (s_rx_byte == CHAR_HASH) begin
                        phase_next = PH_CK_HI;
                    end else if (!overflowed_reg) begin
                        if (kept_count_reg < capacity) begin
                            kept_count_next  = kept_count_reg + 1'b1;
                            running_sum_next = running_sum_reg + s_rx_byte;
                            emit             = 1'b1;
                            word.kind        = KIND_PAYLOAD;
                            word.data        = s_rx_byte;
                        end else begin
                            // First byte that does not fit; the rest are dropped silently.
                            overflowed_next = 1'b1;
                        end
                    end
                end
                PH_CK_HI: begin
                    high_digit_next = s_rx_byte;
                    phase_next      = PH_CK_LO;
                end
                PH_CK_LO: begin
                    phase_next      = PH_IDLE;
                    overflowed_next = 1'b0;
                    emit            = 1'b1;
                    word.kind       = KIND_END;
                    word.length     = kept_count_reg;
                    if (overflowed_reg) begin
                        // An overflowed frame is always answered with an error packet.
                        word.status = STATUS_OVERFLOW;
                        word.reply  = REPLY_E00;
                    end else if (!nib_hi[4] || !nib_lo[4]) begin
                        word.status = STATUS_NOT_HEX;
                        word.reply  = ack_off_reg ? REPLY_NONE : REPLY_MINUS;
                    end else if ({nib_hi[3:0], nib_lo[3:0]} == running_sum_reg) begin
                        word.status = STATUS_GOOD;
                        word.reply  = ack_off_reg ? REPLY_NONE : REPLY_PLUS;
                    end else begin
                        word.status = STATUS_MISMATCH;
                        word.reply  = ack_off_reg ? REPLY_NONE : REPLY_MINUS;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            kept_count_reg  <= '0;
            running_sum_reg <= '0;
            overflowed_reg  <= 1'b0;
            high_digit_reg  <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
            ack_off_reg     <= 1'b0;
            max_payload_reg <= CountWidth'(4096);
        end else begin
            if (accept) begin
                phase_reg       <= phase_next;
                kept_count_reg  <= kept_count_next;
                running_sum_reg <= running_sum_next;
                overflowed_reg  <= overflowed_next;
                high_digit_reg  <= high_digit_next;
            end

            // Output side. The skid entry is only filled while the result register
            // is stalled, and it drains into the result register first.
            if (skid_valid_reg) begin
                if (m_ready) begin
                    out_word_reg   <= skid_word_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept && emit) begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_reg <= 1'b1;
                    out_word_reg  <= word;
                end else begin
                    skid_valid_reg <= 1'b1;
                    skid_word_reg  <= word;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write) begin
                unique case (paddr[2])
                    REG_ACK_OFF:     ack_off_reg     <= pwdata[0];
                    REG_MAX_PAYLOAD: max_payload_reg <= pwdata[CountWidth-1:0];
                    default:         ack_off_reg     <= ack_off_reg;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ACK_OFF:     prdata = {31'd0, ack_off_reg};
            REG_MAX_PAYLOAD: prdata = {{(32 - CountWidth){1'b0}}, max_payload_reg};
            default:         prdata = '0;
        endcase
    end

    assign m_valid  = out_valid_reg;
    assign m_kind   = out_word_reg.kind;
    assign m_data   = out_word_reg.data;
    assign m_status = out_word_reg.status;
    assign m_length = out_word_reg.length;
    assign m_reply  = out_word_reg.reply;

endmodule

@@ rtl/core/rspd_checker.sv @@
// Port-level checker for the packet deframer, bound onto its top level.
// Depends on rspd_pkg for result codes.
module rspd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [1:0]                     m_kind,
    input logic [7:0]                     m_data,
    input logic [1:0]                     m_status,
    input logic [rspd_pkg::CountWidth-1:0] m_length,
    input logic [1:0]                     m_reply
);
    import rspd_pkg::*;

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_data)
            && $stable(m_status) && $stable(m_length) && $stable(m_reply))
        else $error("result word changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind == KIND_PAYLOAD || m_kind == KIND_END || m_kind == KIND_INTR)
        else $error("unknown result kind");

    // Only payload words carry data; only end words carry status, length and reply.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_END |-> m_status == STATUS_GOOD && m_length == '0
            && m_reply == REPLY_NONE)
        else $error("status fields set on a non-end word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_PAYLOAD |-> m_data == 8'd0)
        else $error("data set on a non-payload word");

    // An error packet is the reply to an overflowed frame and nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END |->
            (m_status == STATUS_OVERFLOW) == (m_reply == REPLY_E00))
        else $error("overflow status and error reply disagree");

endmodule

bind rsp_packet_deframer rspd_checker u_rspd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_kind   (m_kind),
    .m_data   (m_data),
    .m_status (m_status),
    .m_length (m_length),
    .m_reply  (m_reply)
);
